### rtl/srs_pkg.sv
// Shared types and constants for the signature region scanner.
// Used by signature_region_scanner and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    // Verdict codes carried on the result stream.
    typedef enum logic [1:0] {
        VERDICT_CLEAN    = 2'd0,
        VERDICT_INFECTED = 2'd1,
        VERDICT_FIRST    = 2'd2,
        VERDICT_LAST     = 2'd3
    } verdict_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_WORD_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_WORD_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_WORD_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_WORD_3 = 3'd5;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned SIG_LEN_W  = 6;
    localparam int unsigned SIG_WORDS  = 4;
    localparam int unsigned SIG_BYTES  = 32;

    // Stream payload widths.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;
    localparam int unsigned VERDICT_W  = 2;

    // Reciprocal of 5 for a 32-bit dividend: q = (x * DIV5_MAGIC) >> DIV5_SHIFT.
    localparam logic [SIZE_W-1:0] DIV5_MAGIC = 32'hCCCC_CCCD;
    localparam int unsigned DIV5_SHIFT = 34;
    localparam int unsigned QUOT_W     = 30;

    // Most result words that can be in flight between input and output.
    localparam int unsigned MAX_IN_FLIGHT = 4;

endpackage : srs_pkg

`default_nettype wire

### rtl/signature_region_scanner.sv
// Top level of the signature region scanner: streaming byte matcher with
// fifth-of-file region tracking. Depends on srs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The slave stream (s_axis_*) carries one file byte per word: tdata holds the
// byte in bits 7:0 and the file size in bits 39:8, and tlast marks the final
// byte of a file. The master stream (m_axis_*) carries one verdict word per
// file, issued for the tlast byte: 0 clean, 1 infected (normal mode) or a hit
// in the middle of the file (fast mode), 2 first fifth, 3 last fifth.
// The configuration channel (cfg_*) writes mode, signature length and the four
// signature words; it is always ready and should be used only while no file is
// in progress.
// Throughput is one byte per clock unless a stalled receiver holds a last
// byte in stage 3. The design is a four-register pipeline: input
// register, match and divide-by-5 multiply, region bounds, and the result
// register. A verdict appears on m_axis_tvalid when the tlast byte enters
// it. The window compare and the 32x32 reciprocal multiply set the cycle time.
// When the receiver stalls, the result register holds its word. Bytes that
// are not the last of a file keep flowing; a last byte waits in stage 3 until
// the result register is free, and once the two stages behind it have filled,
// s_axis_tready drops. Asynchronous reset empties the pipeline, clears
// the window, byte count and hit flags, and restores the default config
// (normal mode, length 1, all-zero signature).
module signature_region_scanner #(
    parameter int SIGNATURE_MAX = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Byte stream in.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: data_byte [7:0], file_size [39:8]
    input  wire  [srs_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // tlast: last_byte
    input  wire                                 s_axis_tlast,
    // Verdict stream out.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata: verdict [1:0], zero [7:2]
    output logic [srs_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // Configuration writes.
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [srs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [srs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int WIN_W  = 8 * SIGNATURE_MAX;
    localparam int LEN_W  = $clog2(SIGNATURE_MAX + 1);
    localparam int CNT_W  = srs_pkg::SIZE_W + 1;
    localparam int PROD_W = 2 * srs_pkg::SIZE_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                                  scan_mode_reg;
    logic [srs_pkg::SIG_LEN_W-1:0]         sig_len_reg;
    logic [srs_pkg::CFG_DATA_W-1:0]        sig_word_reg [srs_pkg::SIG_WORDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= 1'b0;
            sig_len_reg   <= srs_pkg::SIG_LEN_W'(1);
            for (int w = 0; w < srs_pkg::SIG_WORDS; w++)
            begin
                sig_word_reg[w] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srs_pkg::CFG_SCAN_MODE:  scan_mode_reg   <= cfg_data[0];
                srs_pkg::CFG_SIG_LENGTH: sig_len_reg     <= cfg_data[srs_pkg::SIG_LEN_W-1:0];
                srs_pkg::CFG_SIG_WORD_0: sig_word_reg[0] <= cfg_data;
                srs_pkg::CFG_SIG_WORD_1: sig_word_reg[1] <= cfg_data;
                srs_pkg::CFG_SIG_WORD_2: sig_word_reg[2] <= cfg_data;
                srs_pkg::CFG_SIG_WORD_3: sig_word_reg[3] <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Signature alignment. The compare runs against the window with the
    // newest byte at position 0, so the signature is reversed and shifted
    // so that its last byte lines up with position 0. This depends on the
    // configuration only, so it is registered apart from the compare.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]                      len_eff;
    logic [srs_pkg::SIG_BYTES*8-1:0]       sig_flat;
    logic [WIN_W-1:0]                      sig_rev;
    logic [LEN_W-1:0]                      align_shift;
    logic [WIN_W-1:0]                      aligned_next;
    logic [SIGNATURE_MAX-1:0]              mask_next;
    logic [WIN_W-1:0]                      aligned_reg;
    logic [SIGNATURE_MAX-1:0]              mask_reg;
    logic [LEN_W-1:0]                      len_eff_reg;

    // Lengths above the window depth saturate to the window depth.
    always_comb
    begin
        if (7'(sig_len_reg) > 7'(SIGNATURE_MAX))
        begin
            len_eff = LEN_W'(SIGNATURE_MAX);
        end
        else
        begin
            len_eff = LEN_W'(sig_len_reg);
        end
    end

    assign sig_flat = {sig_word_reg[3], sig_word_reg[2], sig_word_reg[1], sig_word_reg[0]};

    // Byte k of sig_rev is signature byte SIGNATURE_MAX-1-k; bytes past the
    // stored 32 read as zero.
    for (genvar k = 0; k < SIGNATURE_MAX; k++)
    begin : g_rev
        localparam int SRC = SIGNATURE_MAX - 1 - k;
        if (SRC < srs_pkg::SIG_BYTES)
        begin : g_stored
            assign sig_rev[8*k +: 8] = sig_flat[8*SRC +: 8];
        end
        else
        begin : g_zero
            assign sig_rev[8*k +: 8] = 8'h00;
        end
    end

    assign align_shift  = LEN_W'(SIGNATURE_MAX) - len_eff;
    assign aligned_next = sig_rev >> {align_shift, 3'b000};

    always_comb
    begin
        for (int j = 0; j < SIGNATURE_MAX; j++)
        begin
            mask_next[j] = (7'(j) < 7'(len_eff));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_reg <= '0;
            mask_reg    <= '0;
            len_eff_reg <= '0;
        end
        else
        begin
            aligned_reg <= aligned_next;
            mask_reg    <= mask_next;
            len_eff_reg <= len_eff;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when the stage after it is free
    // or moving. Stage 3 is consumed outright for a byte that is not the
    // last one, and needs the result register for the last one.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_last_reg,  s2_last_reg,  s3_last_reg;
    logic out_free, adv1, adv2, adv3, rdy1, rdy2, rdy3;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign adv3     = s3_valid_reg && (!s3_last_reg || out_free);
    assign rdy3     = !s3_valid_reg || adv3;
    assign adv2     = s2_valid_reg && rdy3;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign adv1     = s1_valid_reg && rdy2;
    assign rdy1     = !s1_valid_reg || rdy2;

    assign s_axis_tready = rdy1;

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic [srs_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic [srs_pkg::SIZE_W-1:0]  s1_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && rdy1)
        begin
            s1_byte_reg <= s_axis_tdata[srs_pkg::BYTE_W-1:0];
            s1_size_reg <= s_axis_tdata[srs_pkg::BYTE_W +: srs_pkg::SIZE_W];
            s1_last_reg <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: shift the byte into the window, compare against the
    // aligned signature, and start the divide by 5 of the file size.
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]            window_reg;
    logic [srs_pkg::SIZE_W-1:0]  position_reg;
    logic [WIN_W-1:0]            window_shifted;
    logic [SIGNATURE_MAX-1:0]    byte_ok;
    logic [CNT_W-1:0]            count;
    logic                        len_ok;
    logic                        match;
    logic [CNT_W-1:0]            start;
    logic [PROD_W-1:0]           size_prod;

    assign window_shifted = {window_reg[WIN_W-9:0], s1_byte_reg};

    always_comb
    begin
        for (int j = 0; j < SIGNATURE_MAX; j++)
        begin
            byte_ok[j] = !mask_reg[j] || (window_shifted[8*j +: 8] == aligned_reg[8*j +: 8]);
        end
    end

    assign count     = {1'b0, position_reg} + CNT_W'(1);
    assign len_ok    = (len_eff_reg != '0) && (count >= CNT_W'(len_eff_reg));
    assign match     = len_ok && (&byte_ok);
    assign start     = count - CNT_W'(len_eff_reg);
    assign size_prod = s1_size_reg * srs_pkg::DIV5_MAGIC;

    // Window and byte count follow the bytes as they leave stage 1; both
    // start over after the last byte of a file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            position_reg <= '0;
        end
        else if (adv1)
        begin
            if (s1_last_reg)
            begin
                window_reg   <= '0;
                position_reg <= '0;
            end
            else
            begin
                window_reg <= window_shifted;
                if (position_reg != '1)
                begin
                    position_reg <= position_reg + srs_pkg::SIZE_W'(1);
                end
            end
        end
    end

    logic                         s2_match_reg;
    logic [CNT_W-1:0]             s2_start_reg;
    logic [srs_pkg::SIZE_W-1:0]   s2_size_reg;
    logic [srs_pkg::QUOT_W-1:0]   s2_quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_match_reg <= match;
            s2_start_reg <= start;
            s2_size_reg  <= s1_size_reg;
            s2_quot_reg  <= size_prod[srs_pkg::DIV5_SHIFT +: srs_pkg::QUOT_W];
            s2_last_reg  <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 to 3: region bounds. With size = 5q + r, the lower bound is q
    // and the upper bound floor(4*size/5) is 4q + max(r - 1, 0). Only the
    // low three bits are needed to recover r, which is below 5.
    // ------------------------------------------------------------------
    logic [2:0]                   quot5_low;
    logic [2:0]                   rem5;
    logic [1:0]                   hi_adj;
    logic [srs_pkg::SIZE_W-1:0]   hi_bound;

    assign quot5_low = 3'({s2_quot_reg[0], 2'b00}) + s2_quot_reg[2:0];
    assign rem5      = s2_size_reg[2:0] - quot5_low;
    assign hi_adj    = (rem5 == 3'd0) ? 2'd0 : 2'(rem5 - 3'd1);
    assign hi_bound  = {s2_quot_reg, 2'b00} + srs_pkg::SIZE_W'(hi_adj);

    logic                         s3_match_reg;
    logic [CNT_W-1:0]             s3_start_reg;
    logic [srs_pkg::SIZE_W-1:0]   s3_size_reg;
    logic [srs_pkg::QUOT_W-1:0]   s3_lo_reg;
    logic [srs_pkg::SIZE_W-1:0]   s3_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s3_match_reg <= s2_match_reg;
            s3_start_reg <= s2_start_reg;
            s3_size_reg  <= s2_size_reg;
            s3_lo_reg    <= s2_quot_reg;
            s3_hi_reg    <= hi_bound;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: place the match start in a region, fold it into the hit
    // flags and, on the last byte, form the verdict.
    // ------------------------------------------------------------------
    logic hit_first_reg, hit_middle_reg, hit_last_reg;
    logic in_file, below_lo, below_hi;
    logic hit_first_next, hit_middle_next, hit_last_next;
    srs_pkg::verdict_t verdict_next;
    srs_pkg::verdict_t verdict_reg;

    assign in_file  = s3_match_reg && (s3_start_reg < {1'b0, s3_size_reg});
    assign below_lo = s3_start_reg < CNT_W'(s3_lo_reg);
    assign below_hi = s3_start_reg < CNT_W'(s3_hi_reg);

    assign hit_first_next  = hit_first_reg  || (in_file && below_lo);
    assign hit_middle_next = hit_middle_reg || (in_file && !below_lo && below_hi);
    assign hit_last_next   = hit_last_reg   || (in_file && !below_hi);

    always_comb
    begin
        if (!scan_mode_reg)
        begin
            verdict_next = (hit_first_next || hit_middle_next || hit_last_next)
                           ? srs_pkg::VERDICT_INFECTED : srs_pkg::VERDICT_CLEAN;
        end
        else if (hit_middle_next)
        begin
            verdict_next = srs_pkg::VERDICT_INFECTED;
        end
        else if (hit_last_next)
        begin
            verdict_next = srs_pkg::VERDICT_LAST;
        end
        else if (hit_first_next)
        begin
            verdict_next = srs_pkg::VERDICT_FIRST;
        end
        else
        begin
            verdict_next = srs_pkg::VERDICT_CLEAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_first_reg  <= 1'b0;
            hit_middle_reg <= 1'b0;
            hit_last_reg   <= 1'b0;
        end
        else if (adv3)
        begin
            if (s3_last_reg)
            begin
                hit_first_reg  <= 1'b0;
                hit_middle_reg <= 1'b0;
                hit_last_reg   <= 1'b0;
            end
            else
            begin
                hit_first_reg  <= hit_first_next;
                hit_middle_reg <= hit_middle_next;
                hit_last_reg   <= hit_last_next;
            end
        end
    end

    // Result register: loaded by the last byte of a file, emptied when the
    // receiver takes the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv3 && s3_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s3_last_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(srs_pkg::M_TDATA_W - srs_pkg::VERDICT_W)'(0), verdict_reg};

endmodule : signature_region_scanner

`default_nettype wire

### rtl/srs_checker.sv
// Port-level checker for signature_region_scanner, bound to the top level.
// Depends on srs_pkg; watches only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module srs_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire                               s_axis_tlast,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [srs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input wire                               cfg_valid,
    input wire                               cfg_ready
);

    // Files whose last byte went in but whose verdict has not come out yet.
    logic [2:0] pending_reg;
    logic       last_in;
    logic       word_out;

    assign last_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign word_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(last_in) - 3'(word_out);
        end
    end

    // A stalled verdict holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict word changed or dropped while stalled");

    // Every verdict belongs to a file that has ended.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("verdict issued without a finished file");

    // The pipeline holds at most one file end per register.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(srs_pkg::MAX_IN_FLIGHT))
        else $error("more files in flight than pipeline registers");

    // Padding above the verdict is zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[srs_pkg::M_TDATA_W-1:srs_pkg::VERDICT_W] == '0)
        else $error("nonzero padding in verdict word");

    // Configuration port never back-pressures.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule : srs_checker

bind signature_region_scanner srs_checker u_srs_checker (.*);

`default_nettype wire

### sim/tb_signature_region_scanner.sv
// Self-checking testbench for signature_region_scanner: streams file bytes with
// random gaps and output stalls, predicts each verdict and compares it.
// Depends on srs_pkg and the signature_region_scanner RTL.
`timescale 1ns / 1ps

module tb_signature_region_scanner;

    import srs_pkg::*;

    // Scan modes held by the scan_mode register.
    localparam bit MODE_NORMAL = 1'b0;
    localparam bit MODE_FAST   = 1'b1;

    // Register indexes past the last defined one; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest legal stretch is a sender gap plus a receiver stall plus the
    // pipeline and the pause between phases.
    localparam int STALL_LIMIT = 2000;

    // Random bytes planned per configuration phase, and the number of phases.
    localparam int PHASE_BYTES = 72;
    localparam int PHASES      = 12;

    // One file byte as it travels on the input stream.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [SIZE_W-1:0] size;
        logic              last;
    } byte_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    signature_region_scanner uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be driven, and verdicts predicted but not yet seen.
    byte_word_t pending_words[$];
    verdict_t   expected_verdicts[$];

    int  mismatch_count = 0;
    int  bytes_queued   = 0;
    bit  idle_on        = 1'b1;
    bit  s_taken        = 1'b0;
    int  s_gap          = 0;
    int  m_gap          = 0;
    int  quiet_cycles   = 0;

    // Shadow copy of the configuration registers, updated on each accepted write.
    bit                 cfg_mode     = MODE_NORMAL;
    logic [SIG_LEN_W-1:0] cfg_sig_len = 6'd1;
    logic [63:0]        cfg_sig_word [SIG_WORDS] = '{default: '0};

    // Shadow copy of the scan state: window (index 0 newest), count and hit flags.
    logic [BYTE_W-1:0]  win [SIG_BYTES] = '{default: '0};
    logic [SIZE_W-1:0]  pos          = '0;
    bit                 hit_first    = 1'b0;
    bit                 hit_middle   = 1'b0;
    bit                 hit_last     = 1'b0;

    // Directed files for the fast-mode phase: a hit at the start only, hits at
    // both ends (last fifth wins over first), and hits in all three regions
    // (middle wins).
    logic [BYTE_W-1:0] body_first [6] = '{8'hA5, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
    logic [BYTE_W-1:0] body_ends  [6] = '{8'hA5, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h00};
    logic [BYTE_W-1:0] body_all   [6] = '{8'hA5, 8'h00, 8'hA5, 8'h00, 8'hA5, 8'h00};

    function automatic logic [BYTE_W-1:0] sig_byte(input int unsigned idx);
        return cfg_sig_word[idx / 8][(idx % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned active_sig_len();
        return (cfg_sig_len > SIG_BYTES) ? SIG_BYTES : int'(cfg_sig_len);
    endfunction

    // Advances the scan state by one accepted byte and, on the last byte of a
    // file, queues the verdict the block must produce.
    task automatic scan_byte(input byte_word_t w);
        int unsigned     eff;
        int              i;
        bit              hit;
        longint unsigned seen;
        longint unsigned start;
        longint unsigned lo;
        longint unsigned hi;
        verdict_t        verdict;
        eff = active_sig_len();
        for (i = SIG_BYTES - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = w.data;
        seen = longint'(pos) + 1;
        if (eff > 0 && seen >= eff)
        begin
            hit = 1'b1;
            for (i = 0; i < eff; i++)
                if (sig_byte(i) != win[eff - 1 - i])
                    hit = 1'b0;
            if (hit)
            begin
                // Region bounds come from the size carried by this byte; a match
                // starting at or past the size belongs to no region.
                start = seen - eff;
                lo    = longint'(w.size) / 5;
                hi    = (longint'(w.size) * 4) / 5;
                if (start < longint'(w.size))
                begin
                    if (start < lo)
                        hit_first = 1'b1;
                    else if (start < hi)
                        hit_middle = 1'b1;
                    else
                        hit_last = 1'b1;
                end
            end
        end
        if (pos != '1)
            pos++;
        if (w.last)
        begin
            if (cfg_mode == MODE_NORMAL)
                verdict = (hit_first || hit_middle || hit_last) ? VERDICT_INFECTED
                                                                 : VERDICT_CLEAN;
            else if (hit_middle)
                verdict = VERDICT_INFECTED;
            else if (hit_last)
                verdict = VERDICT_LAST;
            else if (hit_first)
                verdict = VERDICT_FIRST;
            else
                verdict = VERDICT_CLEAN;
            expected_verdicts.push_back(verdict);
            win        = '{default: '0};
            pos        = '0;
            hit_first  = 1'b0;
            hit_middle = 1'b0;
            hit_last   = 1'b0;
        end
    endtask

    // Configuration writes and input words are mirrored at the edge that
    // accepts them, so the prediction always uses the settings the block saw.
    always @(posedge clk)
    begin : scan_predictor
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCAN_MODE:  cfg_mode        = cfg_data[0];
                    CFG_SIG_LENGTH: cfg_sig_len     = cfg_data[SIG_LEN_W-1:0];
                    CFG_SIG_WORD_0: cfg_sig_word[0] = cfg_data;
                    CFG_SIG_WORD_1: cfg_sig_word[1] = cfg_data;
                    CFG_SIG_WORD_2: cfg_sig_word[2] = cfg_data;
                    CFG_SIG_WORD_3: cfg_sig_word[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                scan_byte('{data: s_axis_tdata[BYTE_W-1:0],
                            size: s_axis_tdata[BYTE_W +: SIZE_W],
                            last: s_axis_tlast});
        end
        s_taken <= s_axis_tvalid && s_axis_tready;
    end

    // Byte driver: holds a word until it is taken, otherwise either opens an
    // idle burst or presents the next pending word.
    always @(negedge clk)
    begin : byte_driver
        byte_word_t w;
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_taken)
            begin
                // Word still on the bus; keep it steady.
            end
            else if (s_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_gap = s_gap - 1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_gap = $urandom_range(0, 7);
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                s_axis_tdata  <= {w.size, w.data};
                s_axis_tlast  <= w.last;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Verdict receiver: ready most of the time, with stall bursts.
    always @(negedge clk)
    begin : verdict_receiver
        if (rst_n)
        begin
            if (m_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                m_gap = m_gap - 1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                m_gap = $urandom_range(0, 7);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every verdict word is matched against the oldest prediction; the padding
    // above the verdict field must read as zero.
    always @(posedge clk)
    begin : verdict_monitor
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: verdict word 0x%02h arrived with none expected",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata !== {{(M_TDATA_W - VERDICT_W){1'b0}}, want})
                begin
                    $display("%0t: verdict mismatch, expected 0x%02h actual 0x%02h",
                             $time, {{(M_TDATA_W - VERDICT_W){1'b0}}, want},
                             m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // A run that stops accepting words on every channel has hung.
    always @(posedge clk)
    begin : stall_watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("signature_region_scanner regression: fail");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] data, input logic [SIZE_W-1:0] size,
                             input logic last);
        pending_words.push_back('{data: data, size: size, last: last});
        bytes_queued++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every byte has been taken and every verdict has arrived, then
    // lets the pipeline drain.
    task automatic wait_idle();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Builds one file: bytes drawn partly from the signature alphabet so that
    // near misses are common, usually with the whole signature planted once or
    // twice, and a declared size that mostly matches the real length.
    task automatic queue_file();
        logic [BYTE_W-1:0] body [64];
        int unsigned       eff;
        int unsigned       flen;
        int unsigned       at;
        int unsigned       k;
        int unsigned       size_kind;
        int unsigned       plant;
        logic [SIZE_W-1:0] size;
        eff  = active_sig_len();
        flen = $urandom_range(1, ((eff > 0) ? eff : 1) + 10);
        for (k = 0; k < flen; k++)
            body[k] = (eff > 0 && $urandom_range(0, 1) == 1)
                      ? sig_byte($urandom_range(0, eff - 1)) : 8'($urandom_range(0, 255));
        if (eff > 0 && eff <= flen)
            for (plant = 0; plant < 2; plant++)
                if ($urandom_range(0, 2) != 0)
                begin
                    at = $urandom_range(0, flen - eff);
                    for (k = 0; k < eff; k++)
                        body[at + k] = sig_byte(k);
                end
        size_kind = $urandom_range(0, 19);
        if (size_kind < 14)
            size = flen;
        else if (size_kind < 16)
            size = $urandom_range(1, flen);
        else if (size_kind < 18)
            size = flen + $urandom_range(1, 20);
        else
            size = $urandom;
        for (k = 0; k < flen; k++)
            // The last kind changes the declared size from byte to byte.
            push_word(body[k], (size_kind == 19) ? SIZE_W'($urandom_range(1, flen + 4)) : size,
                      k == flen - 1);
    endtask

    initial
    begin : stimulus
        int                    phase;
        int                    target;
        int unsigned           new_len;
        bit                    new_mode;
        logic [CFG_DATA_W-1:0] noise;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: normal mode, one null signature byte. A lone null
        // byte in a one-byte file lands in the last fifth; a file of size zero
        // has no regions at all; an all-ones byte with the largest size is clean.
        push_word(8'h00, 32'd1, 1'b1);
        push_word(8'hFF, 32'hFFFF_FFFF, 1'b1);
        push_word(8'h00, 32'd0, 1'b1);
        wait_idle();

        // Fast mode with a two-byte signature whose second byte is null. With
        // six bytes the first fifth is position 0 and the last fifth starts at 4.
        cfg_write(CFG_SCAN_MODE, 64'(MODE_FAST));
        cfg_write(CFG_SIG_LENGTH, 64'd2);
        cfg_write(CFG_SIG_WORD_0, 64'h0000_0000_0000_00A5);
        cfg_release();
        foreach (body_first[k])
            push_word(body_first[k], 32'd6, k == 5);
        foreach (body_ends[k])
            push_word(body_ends[k], 32'd6, k == 5);
        foreach (body_all[k])
            push_word(body_all[k], 32'd6, k == 5);
        // Fewer bytes than the signature: the prefix alone never matches.
        push_word(8'hA5, 32'd1, 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            idle_on = (phase != PHASES - 1) && (phase % 5 != 4);

            // The first phases cover the length extremes: zero never matches,
            // 32 uses the whole window and 63 saturates to the window size.
            new_mode = (phase == 0) ? MODE_NORMAL : MODE_FAST ^ ($urandom_range(0, 1) == 1);
            case (phase)
                0:       new_len = 0;
                1:       new_len = SIG_BYTES;
                2:       new_len = 63;
                default: new_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, SIG_BYTES)
                                                                : $urandom_range(1, 8);
            endcase
            // Upper data bits are noise that the block must drop.
            noise = {$urandom, $urandom};
            cfg_write(CFG_SCAN_MODE, {noise[63:1], new_mode});
            noise = {$urandom, $urandom};
            cfg_write(CFG_SIG_LENGTH, {noise[63:SIG_LEN_W], SIG_LEN_W'(new_len)});
            cfg_write(CFG_SIG_WORD_0, (phase == 2) ? '1 : {$urandom, $urandom});
            cfg_write(CFG_SIG_WORD_1, (phase == 2) ? '1 : {$urandom, $urandom});
            cfg_write(CFG_SIG_WORD_2, (phase == 2) ? '1 : {$urandom, $urandom});
            cfg_write(CFG_SIG_WORD_3, (phase == 2) ? '1 : {$urandom, $urandom});
            if (phase == 3 || $urandom_range(0, 3) == 0)
            begin
                cfg_write(CFG_SPARE_A, {$urandom, $urandom});
                cfg_write(CFG_SPARE_B, {$urandom, $urandom});
            end
            cfg_release();

            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                queue_file();
        end

        wait_idle();
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("signature_region_scanner regression: pass");
        else
            $display("signature_region_scanner regression: fail");
        $finish;
    end

endmodule
